// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/mfps_pkg.sv -----
// Shared types and fixed constants of the minimum falling path sum block.
`default_nettype none

package mfps_pkg;

   // Fixed field widths, reset size and queue depth
   localparam int CELL_W      = 16;
   localparam int SUM_W       = 22;
   localparam int CSR_W       = 7;
   localparam int RESET_SIZE  = 64;
   localparam int QUEUE_DEPTH = 4;

   // Saturation limits of a path sum
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Position of one cell within the matrix
   typedef struct packed {
      logic row0;
      logic last_row;
      logic first_col;
      logic last_col;
   } flags_type;

   // Back-end status seen by the top level
   typedef struct packed {
      logic emit;
      logic out_blocked;
   } back_stat_type;

   localparam int FLAGS_W = $bits(flags_type);

endpackage

`default_nettype wire

// ----- rtl/core/mfps_ifs.sv -----
// Valid/ready channel interfaces for cells in and path sums out.
`default_nettype none

interface mfps_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mfps_pkg::CELL_W-1:0]  cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

interface mfps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mfps_pkg::SUM_W-1:0]   path_sum;

   modport source (output valid, output path_sum, input ready);
   modport sink   (input valid, input path_sum, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mfps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mfps_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64,
   localparam int A_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [A_W-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic                   rd_en,
   input  wire logic [A_W-1:0]         rd_addr,
   output      logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mfps_queue.sv -----
// Small FIFO between the front end and the back end.
`default_nettype none

module mfps_queue #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] pop_data,
   output      logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

`default_nettype wire

// ----- rtl/core/mfps_front.sv -----
// Front end: takes cells, tracks row and column, tags each item for the back end.
`default_nettype none

module mfps_front #(
   parameter int MAX_SIZE = 64,
   localparam int P_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mfps_req_if.sink                              req_if,
   input  wire logic                             csr_wr_en,
   input  wire logic [mfps_pkg::CSR_W-1:0]       csr_wr_data,
   input  wire logic                             q_full,
   output      logic                             push,
   output      logic [P_W-1:0]                   cmd_col,
   output      mfps_pkg::flags_type              cmd_flags,
   output      logic signed [mfps_pkg::CELL_W-1:0] cmd_cell
);

   localparam int SZ_W0 = $clog2(MAX_SIZE + 1);
   localparam int N_W   = (SZ_W0 > mfps_pkg::CSR_W) ? SZ_W0 : mfps_pkg::CSR_W;
   localparam int RST_N = (mfps_pkg::RESET_SIZE > MAX_SIZE) ? MAX_SIZE
                                                            : mfps_pkg::RESET_SIZE;

   logic [N_W-1:0] size_ff, size_in;
   logic [P_W-1:0] col_ff,  col_in;
   logic [P_W-1:0] row_ff,  row_in;
   logic [N_W-1:0] csr_ext;
   logic           accept;
   logic           last_col;
   logic           last_row;

   // Effective size: zero acts as one, clamp at the store depth
   assign csr_ext = N_W'(csr_wr_data);
   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         if (csr_ext == '0) begin
            size_in = N_W'(1);
         end else if (csr_ext > N_W'(MAX_SIZE)) begin
            size_in = N_W'(MAX_SIZE);
         end else begin
            size_in = csr_ext;
         end
      end
   end

   assign accept    = req_if.valid && !q_full;
   assign last_col  = (N_W'(col_ff) + N_W'(1)) == size_ff;
   assign last_row  = (N_W'(row_ff) + N_W'(1)) == size_ff;

   // Position walk; a size write re-arms
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr_en) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + P_W'(1);
         end else begin
            col_in = col_ff + P_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= N_W'(RST_N);
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         size_ff <= size_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   // Tagged item toward the queue
   assign req_if.ready        = !q_full;
   assign push                = accept;
   assign cmd_col             = col_ff;
   assign cmd_cell            = req_if.cell_value;
   assign cmd_flags.row0      = (row_ff == '0);
   assign cmd_flags.last_row  = last_row;
   assign cmd_flags.first_col = (col_ff == '0);
   assign cmd_flags.last_col  = last_col;

endmodule

`default_nettype wire

// ----- rtl/core/mfps_back.sv -----
// Back end: row-store update, neighbor window, running minimum and result register.
`default_nettype none

module mfps_back #(
   parameter int MAX_SIZE = 64,
   localparam int P_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_empty,
   output      logic                               q_pop,
   input  wire logic [P_W-1:0]                     cmd_col,
   input  wire mfps_pkg::flags_type                cmd_flags,
   input  wire logic signed [mfps_pkg::CELL_W-1:0] cmd_cell,
   mfps_rsp_if.source                              rsp_if,
   output      mfps_pkg::back_stat_type            stat
);

   localparam int SW  = mfps_pkg::SUM_W;
   localparam int CW  = mfps_pkg::CELL_W;

   // Execute stage
   logic                    b_valid_ff, b_valid_in;
   logic [P_W-1:0]          b_col_ff;
   mfps_pkg::flags_type     b_flags_ff;
   logic signed [CW-1:0]    b_cell_ff;
   logic                    fwd_hit_ff;
   logic signed [SW-1:0]    fwd_data_ff;

   // Neighbor window and running minimum
   logic signed [SW-1:0]    up_next_ff;
   logic signed [SW-1:0]    left_ff;
   logic signed [SW-1:0]    col0_ff;
   logic signed [SW-1:0]    min_ff;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]    rsp_sum_ff;

   logic [P_W-1:0]          rd_addr;
   logic [SW-1:0]           ram_rdata;
   logic signed [SW-1:0]    right_val;
   logic signed [SW-1:0]    up_val;
   logic signed [SW-1:0]    best;
   logic signed [SW:0]      sum_wide;
   logic signed [SW-1:0]    sum_sat;
   logic signed [SW-1:0]    cell_ext;
   logic signed [SW-1:0]    fresh;
   logic signed [SW-1:0]    new_min;
   logic                    emit;
   logic                    out_free;
   logic                    b_fire;

   // Row store: read the up-right entry as an item leaves the queue
   assign rd_addr = cmd_col + P_W'(1);

   mfps_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_SIZE)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (b_fire),
      .wr_addr (b_col_ff),
      .wr_data (fresh),
      .rd_en   (q_pop),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Old-row neighbors
   assign right_val = fwd_hit_ff ? fwd_data_ff : $signed(ram_rdata);
   assign up_val    = b_flags_ff.first_col ? col0_ff : up_next_ff;

   always_comb begin
      best = up_val;
      if (!b_flags_ff.first_col && (left_ff < best)) begin
         best = left_ff;
      end
      if (!b_flags_ff.last_col && (right_val < best)) begin
         best = right_val;
      end
   end

   // Saturating add of the cell to the best neighbor
   assign cell_ext = {{(SW-CW){b_cell_ff[CW-1]}}, b_cell_ff};
   assign sum_wide = {best[SW-1], best} + {cell_ext[SW-1], cell_ext};

   always_comb begin
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         sum_sat = sum_wide[SW] ? mfps_pkg::SUM_MIN : mfps_pkg::SUM_MAX;
      end else begin
         sum_sat = sum_wide[SW-1:0];
      end
   end

   assign fresh   = b_flags_ff.row0 ? cell_ext : sum_sat;
   assign new_min = (b_flags_ff.first_col || (fresh < min_ff)) ? fresh : min_ff;

   // Handshake between stages
   assign emit     = b_flags_ff.last_row && b_flags_ff.last_col;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign b_fire   = b_valid_ff && (!emit || out_free);
   assign q_pop    = !q_empty && (!b_valid_ff || b_fire);

   always_comb begin
      b_valid_in = b_valid_ff;
      if (q_pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         min_ff       <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            fwd_hit_ff <= b_fire && (b_col_ff == rd_addr);
         end
         if (b_fire && b_flags_ff.last_row) begin
            min_ff <= new_min;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_col_ff    <= cmd_col;
         b_flags_ff  <= cmd_flags;
         b_cell_ff   <= cmd_cell;
         fwd_data_ff <= fresh;
      end
      if (b_fire) begin
         up_next_ff <= right_val;
         left_ff    <= up_val;
         if (b_flags_ff.first_col) begin
            col0_ff <= fresh;
         end
      end
      if (b_fire && emit) begin
         rsp_sum_ff <= new_min;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.path_sum  = rsp_sum_ff;
   assign stat.emit        = b_fire && emit;
   assign stat.out_blocked = rsp_valid_ff && !rsp_if.ready;

endmodule

`default_nettype wire

// ----- rtl/core/min_falling_path_sum.sv -----
// Top level of the minimum falling path sum block.
// One cell per cycle unless stalled; each item does one row-store read and one write.
// The last cell passes the queue and the execute stage; the sum is then registered.
// Input stalls only when the four-entry queue fills behind an unread result.
// Reset: synchronous, active high; size goes to min(64, MAX_SIZE); position re-arms.
`default_nettype none
`include "assert_macros.svh"

module min_falling_path_sum #(
   parameter int MAX_SIZE = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [mfps_pkg::CSR_W-1:0] csr_wr_data,
   mfps_req_if.sink                        req_if,
   mfps_rsp_if.source                      rsp_if
);

   localparam int P_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int Q_W = P_W + mfps_pkg::FLAGS_W + mfps_pkg::CELL_W;

   logic                                q_push;
   logic                                q_pop;
   logic                                q_full;
   logic                                q_empty;
   logic [Q_W-1:0]                      q_in;
   logic [Q_W-1:0]                      q_out;
   logic [P_W-1:0]                      f_col;
   mfps_pkg::flags_type                 f_flags;
   logic signed [mfps_pkg::CELL_W-1:0]  f_cell;
   logic [P_W-1:0]                      b_col;
   mfps_pkg::flags_type                 b_flags;
   logic signed [mfps_pkg::CELL_W-1:0]  b_cell;
   mfps_pkg::back_stat_type             back_stat;

   // Front end
   mfps_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (q_push),
      .cmd_col     (f_col),
      .cmd_flags   (f_flags),
      .cmd_cell    (f_cell)
   );

   // Item queue
   assign q_in = {f_col, f_flags, f_cell};

   mfps_queue #(
      .WIDTH (Q_W),
      .DEPTH (mfps_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign {b_col, b_flags, b_cell} = q_out;

   // Back end
   mfps_back #(
      .MAX_SIZE (MAX_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .cmd_col   (b_col),
      .cmd_flags (b_flags),
      .cmd_cell  (b_cell),
      .rsp_if    (rsp_if),
      .stat      (back_stat)
   );

   // Checks
   `ASSERT_IMP(a_pop_not_empty, clock, reset, q_pop, !q_empty)
   `ASSERT_IMP(a_no_result_overwrite, clock, reset, back_stat.out_blocked, !back_stat.emit)
   `ASSERT_NXT(a_emit_shows_result, clock, reset, back_stat.emit, rsp_if.valid)

endmodule

`default_nettype wire
